/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define XLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/xlt_pkg.sv */
package xlt_pkg;

    // result kinds
    localparam logic [3:0] K_DIMS      = 4'd0;
    localparam logic [3:0] K_DOUBLE    = 4'd1;
    localparam logic [3:0] K_STR_BYTE  = 4'd2;
    localparam logic [3:0] K_STR_EMPTY = 4'd3;
    localparam logic [3:0] K_BOOL      = 4'd4;
    localparam logic [3:0] K_ERR_CELL  = 4'd5;
    localparam logic [3:0] K_BLANK     = 4'd6;
    localparam logic [3:0] K_INT       = 4'd7;
    localparam logic [3:0] K_FMT_ERR   = 4'd8;
    localparam logic [3:0] K_DONE      = 4'd9;

    // column wrap divider: (col + count) / col_count
    localparam int DIVIDEND_W = 17;
    localparam int DIVISOR_W  = 16;

    // result queue
    localparam int FIFO_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] row;
        logic [15:0] col;
        logic [63:0] value;
        logic        cell_end;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res_a;
        t_result    res_b;
    } t_push;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

endpackage

/* hdl/xlt_if.sv */
interface xlt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface xlt_result_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [63:0] value;
    logic        cell_end;
    logic        last_result;

    modport source (output valid, output kind, output row, output col, output value,
                    output cell_end, output last_result, input ready);
    modport sink   (input valid, input kind, input row, input col, input value,
                    input cell_end, input last_result, output ready);
endinterface

/* hdl/xltable_stream_parser.sv */
// Channel   Direction  Word
// i_byte    in         data_byte[7:0], last_byte
// o_result  out        kind[3:0], row, col, value[63:0], cell_end, last_result
//
// One byte per cycle; each byte pushes up to two results into a 4-entry result queue.
// A blank run with a nonzero count stalls the input: the 17-step column wrap divider
// holds i_byte.ready low until the new row and column are known.
// i_byte.ready is also low while more than two results wait in the queue.
// Synchronous active-low reset returns the parser to the header phase.
`include "assert_macros.svh"

module xltable_stream_parser
    import xlt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    xlt_byte_if.sink      i_byte,
    xlt_result_if.source  o_result
);

    localparam logic [2:0] PH_HDR     = 3'd0;
    localparam logic [2:0] PH_TYPE    = 3'd1;
    localparam logic [2:0] PH_SIZE    = 3'd2;
    localparam logic [2:0] PH_FIXED   = 3'd3;
    localparam logic [2:0] PH_STRLEN  = 3'd4;
    localparam logic [2:0] PH_STRDATA = 3'd5;
    localparam logic [2:0] PH_DISCARD = 3'd6;
    localparam logic [2:0] PH_HALT    = 3'd7;

    localparam logic [15:0] T_FLOAT  = 16'd1;
    localparam logic [15:0] T_STRING = 16'd2;
    localparam logic [15:0] T_BOOL   = 16'd3;
    localparam logic [15:0] T_ERROR  = 16'd4;
    localparam logic [15:0] T_BLANK  = 16'd5;
    localparam logic [15:0] T_INT    = 16'd6;
    localparam logic [15:0] T_SKIP   = 16'd7;
    localparam logic [15:0] T_TABLE  = 16'd16;
    localparam logic [15:0] HDR_SIZE = 16'd4;

    logic [2:0]  r_phase,       n_phase;
    logic [3:0]  r_bytes_seen,  n_bytes_seen;
    logic [2:0]  r_byte_index,  n_byte_index;
    logic [7:0]  r_string_left, n_string_left;
    logic [15:0] r_row_count,   n_row_count;
    logic [15:0] r_col_count,   n_col_count;
    logic [15:0] r_cur_row,     n_cur_row;
    logic [15:0] r_cur_col,     n_cur_col;
    logic [15:0] r_block_type,  n_block_type;
    logic [15:0] r_block_left,  n_block_left;
    logic [63:0] r_assembly,    n_assembly;

    logic                        acc;
    logic [7:0]                  b;
    logic                        last;
    logic [15:0]                 w;
    logic                        word_done;
    logic                        err;
    logic                        adv1;
    logic                        blank_go;
    logic [15:0]                 bl;
    logic [7:0]                  sl;
    logic [63:0]                 asm_or;
    logic [1:0]                  nres;
    t_result                     res [2];
    t_push                       push;
    t_div_req                    div_req;
    t_div_rsp                    div_rsp;
    logic [$clog2(FIFO_DEPTH):0] fifo_count;

    function automatic t_result mk(input logic [3:0] k, input logic [15:0] r,
                                   input logic [15:0] c, input logic [63:0] v,
                                   input logic e);
        t_result t;
        t.kind        = k;
        t.row         = r;
        t.col         = c;
        t.value       = v;
        t.cell_end    = e;
        t.last_result = 1'b0;
        return t;
    endfunction

    assign b    = i_byte.data_byte;
    assign last = i_byte.last_byte;
    assign i_byte.ready = !div_rsp.busy && (fifo_count <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH - 2));
    assign acc  = i_byte.valid && i_byte.ready;

    // 16-bit words arrive low byte first; the low byte waits in the assembly register
    assign w         = {b, r_assembly[7:0]};
    assign word_done = (r_byte_index != 3'd0);
    assign asm_or    = r_assembly | ({56'd0, b} << {r_byte_index, 3'b000});

    always_comb begin
        n_phase       = r_phase;
        n_bytes_seen  = r_bytes_seen;
        n_byte_index  = r_byte_index;
        n_string_left = r_string_left;
        n_row_count   = r_row_count;
        n_col_count   = r_col_count;
        n_cur_row     = r_cur_row;
        n_cur_col     = r_cur_col;
        n_block_type  = r_block_type;
        n_block_left  = r_block_left;
        n_assembly    = r_assembly;
        err      = 1'b0;
        adv1     = 1'b0;
        blank_go = 1'b0;
        nres     = 2'd0;
        res[0]   = '0;
        res[1]   = '0;
        bl       = r_block_left - 16'd1;
        sl       = r_string_left - 8'd1;

        // word pickup shared by the phases that read 16-bit words
        if ((r_phase == PH_HDR) || (r_phase == PH_TYPE) || (r_phase == PH_SIZE) ||
            ((r_phase == PH_FIXED) && (r_block_type != T_FLOAT))) begin
            if (word_done) begin
                n_byte_index = 3'd0;
                n_assembly   = '0;
            end else begin
                n_byte_index = 3'd1;
                n_assembly   = {56'd0, b};
            end
        end

        case (r_phase)
            PH_HDR: begin
                n_bytes_seen = r_bytes_seen + 4'd1;
                if (word_done) begin
                    if ((r_bytes_seen == 4'd1) && (w != T_TABLE)) begin
                        err = 1'b1;
                    end else if ((r_bytes_seen == 4'd3) && (w != HDR_SIZE)) begin
                        err = 1'b1;
                    end else if (r_bytes_seen == 4'd5) begin
                        n_row_count = w;
                    end else if (r_bytes_seen == 4'd7) begin
                        n_col_count = w;
                        if ((r_row_count == 16'd0) || (w == 16'd0)) begin
                            err = 1'b1;
                        end else begin
                            res[nres[0]] = mk(K_DIMS, 16'd0, 16'd0,
                                              {32'd0, r_row_count, w}, 1'b0);
                            nres = nres + 2'd1;
                            n_phase = PH_TYPE;
                        end
                    end
                end
            end
            PH_TYPE: begin
                if (word_done) begin
                    n_block_type = w;
                    if (w == T_SKIP) begin
                        err = 1'b1;
                    end else begin
                        n_phase = PH_SIZE;
                    end
                end
            end
            PH_SIZE: begin
                if (word_done) begin
                    n_block_left = w;
                    case (r_block_type)
                        T_FLOAT:                 err = (w[2:0] != 3'd0);
                        T_BOOL, T_ERROR, T_INT:  err = w[0];
                        T_BLANK:                 err = (w != 16'd2);
                        default:                 err = 1'b0;
                    endcase
                    if (!err) begin
                        if (w == 16'd0) begin
                            n_phase = PH_TYPE;
                        end else if (r_block_type == T_STRING) begin
                            n_phase = PH_STRLEN;
                        end else if ((r_block_type >= T_FLOAT) && (r_block_type <= T_INT)) begin
                            n_phase = PH_FIXED;
                        end else begin
                            n_phase = PH_DISCARD;
                        end
                    end
                end
            end
            PH_FIXED: begin
                n_block_left = bl;
                if (r_block_type == T_FLOAT) begin
                    if (r_byte_index == 3'd7) begin
                        res[nres[0]] = mk(K_DOUBLE, r_cur_row, r_cur_col, asm_or, 1'b1);
                        nres = nres + 2'd1;
                        adv1 = 1'b1;
                        n_byte_index = 3'd0;
                        n_assembly   = '0;
                    end else begin
                        n_assembly   = asm_or;
                        n_byte_index = r_byte_index + 3'd1;
                    end
                end else if (word_done) begin
                    case (r_block_type)
                        T_BOOL: begin
                            res[nres[0]] = mk(K_BOOL, r_cur_row, r_cur_col,
                                              {63'd0, (w != 16'd0)}, 1'b1);
                            nres = nres + 2'd1;
                            adv1 = 1'b1;
                        end
                        T_ERROR: begin
                            res[nres[0]] = mk(K_ERR_CELL, r_cur_row, r_cur_col,
                                              {48'd0, w}, 1'b1);
                            nres = nres + 2'd1;
                            adv1 = 1'b1;
                        end
                        T_INT: begin
                            res[nres[0]] = mk(K_INT, r_cur_row, r_cur_col,
                                              {48'd0, w}, 1'b1);
                            nres = nres + 2'd1;
                            adv1 = 1'b1;
                        end
                        default: begin
                            // blank run: position moves through the divider
                            if (w != 16'd0) begin
                                res[nres[0]] = mk(K_BLANK, r_cur_row, r_cur_col,
                                                  {48'd0, w}, 1'b1);
                                nres = nres + 2'd1;
                                blank_go = 1'b1;
                            end
                        end
                    endcase
                end
                if (bl == 16'd0) begin
                    n_phase = PH_TYPE;
                end
            end
            PH_STRLEN: begin
                if (r_block_left != 16'd0) begin
                    n_block_left = bl;
                end
                if (b == 8'd0) begin
                    res[nres[0]] = mk(K_STR_EMPTY, r_cur_row, r_cur_col, 64'd0, 1'b1);
                    nres = nres + 2'd1;
                    adv1 = 1'b1;
                    if (n_block_left == 16'd0) begin
                        n_phase = PH_TYPE;
                    end
                end else begin
                    n_string_left = b;
                    n_phase = PH_STRDATA;
                end
            end
            PH_STRDATA: begin
                if (r_block_left != 16'd0) begin
                    n_block_left = bl;
                end
                n_string_left = sl;
                res[nres[0]] = mk(K_STR_BYTE, r_cur_row, r_cur_col, {56'd0, b},
                                  (sl == 8'd0));
                nres = nres + 2'd1;
                if (sl == 8'd0) begin
                    adv1 = 1'b1;
                    n_phase = (n_block_left != 16'd0) ? PH_STRLEN : PH_TYPE;
                end
            end
            PH_DISCARD: begin
                n_block_left = bl;
                if (bl == 16'd0) begin
                    n_phase = PH_TYPE;
                end
            end
            default: begin
            end
        endcase

        // the column stays below col_count, so a single step wraps on equality
        if (adv1) begin
            if ({1'b0, r_cur_col} + 17'd1 == {1'b0, r_col_count}) begin
                n_cur_col = 16'd0;
                n_cur_row = r_cur_row + 16'd1;
            end else begin
                n_cur_col = r_cur_col + 16'd1;
            end
        end

        if (err) begin
            res[nres[0]] = mk(K_FMT_ERR, 16'd0, 16'd0, 64'd0, 1'b0);
            nres = nres + 2'd1;
            n_phase = PH_HALT;
        end

        if (last) begin
            if (n_phase != PH_HALT) begin
                if ((n_phase == PH_TYPE) && (n_byte_index == 3'd0)) begin
                    res[nres[0]] = mk(K_DONE, 16'd0, 16'd0, 64'd0, 1'b0);
                end else begin
                    res[nres[0]] = mk(K_FMT_ERR, 16'd0, 16'd0, 64'd0, 1'b0);
                end
                nres = nres + 2'd1;
            end
            n_phase       = PH_HDR;
            n_bytes_seen  = '0;
            n_byte_index  = '0;
            n_string_left = '0;
            n_row_count   = '0;
            n_col_count   = '0;
            n_cur_row     = '0;
            n_cur_col     = '0;
            n_block_type  = '0;
            n_block_left  = '0;
            n_assembly    = '0;
        end

        if (nres == 2'd1) begin
            res[0].last_result = 1'b1;
        end else if (nres == 2'd2) begin
            res[1].last_result = 1'b1;
        end
    end

    assign div_req.start    = acc && blank_go && !last;
    assign div_req.dividend = {1'b0, r_cur_col} + {1'b0, w};
    assign div_req.divisor  = r_col_count;

    assign push.count = acc ? nres : 2'd0;
    assign push.res_a = res[0];
    assign push.res_b = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HDR;
            r_bytes_seen  <= '0;
            r_byte_index  <= '0;
            r_string_left <= '0;
            r_row_count   <= '0;
            r_col_count   <= '0;
            r_cur_row     <= '0;
            r_cur_col     <= '0;
            r_block_type  <= '0;
            r_block_left  <= '0;
            r_assembly    <= '0;
        end else if (acc) begin
            r_phase       <= n_phase;
            r_bytes_seen  <= n_bytes_seen;
            r_byte_index  <= n_byte_index;
            r_string_left <= n_string_left;
            r_row_count   <= n_row_count;
            r_col_count   <= n_col_count;
            r_cur_row     <= n_cur_row;
            r_cur_col     <= n_cur_col;
            r_block_type  <= n_block_type;
            r_block_left  <= n_block_left;
            r_assembly    <= n_assembly;
        end else if (div_rsp.done) begin
            r_cur_row <= r_cur_row + div_rsp.quotient[15:0];
            r_cur_col <= div_rsp.remainder;
        end
    end

    xlt_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    xlt_result_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_count  (fifo_count),
        .o_result (o_result)
    );

    `XLT_ASSERT(a_ready_not_dividing, i_clk, i_rst_n, i_byte.ready |-> !div_rsp.busy, "byte taken while divider busy")
    `XLT_ASSERT(a_div_start_on_word, i_clk, i_rst_n, div_req.start |-> (acc && (r_phase == PH_FIXED)), "divider started outside a blank word")
    `XLT_ASSERT(a_div_runs, i_clk, i_rst_n, div_req.start |=> (div_rsp.busy && !i_byte.ready), "divider did not hold the input")
    `XLT_ASSERT(a_blank_nonzero_cols, i_clk, i_rst_n, div_req.start |-> (r_col_count != 16'd0), "blank run with zero column count")

endmodule

/* hdl/xlt_divider.sv */
module xlt_divider
    import xlt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CntW = $clog2(DIVIDEND_W + 1);

    logic [CntW-1:0]       r_cnt;
    logic [DIVIDEND_W-1:0] r_rem;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_div;
    logic [DIVIDEND_W-1:0] n_rem;
    logic [DIVIDEND_W-1:0] n_quo;
    logic [DIVIDEND_W-1:0] trial;

    // one restoring step per cycle, dividend bits shifted in from the top
    always_comb begin
        trial = {r_rem[DIVIDEND_W-2:0], r_quo[DIVIDEND_W-1]};
        if (trial >= {{(DIVIDEND_W-DIVISOR_W){1'b0}}, r_div}) begin
            n_rem = trial - {{(DIVIDEND_W-DIVISOR_W){1'b0}}, r_div};
            n_quo = {r_quo[DIVIDEND_W-2:0], 1'b1};
        end else begin
            n_rem = trial;
            n_quo = {r_quo[DIVIDEND_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_req.start) begin
            r_cnt <= CntW'(DIVIDEND_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.busy      = (r_cnt != '0);
    assign o_rsp.done      = (r_cnt == CntW'(1));
    assign o_rsp.quotient  = n_quo;
    assign o_rsp.remainder = n_rem[DIVISOR_W-1:0];

endmodule

/* hdl/xlt_result_fifo.sv */
`include "assert_macros.svh"

module xlt_result_fifo
    import xlt_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_push                       i_push,
    output logic [$clog2(FIFO_DEPTH):0] o_count,
    xlt_result_if.source                o_result
);

    localparam int PtrW = $clog2(FIFO_DEPTH);

    t_result          r_mem [FIFO_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [PtrW:0]    r_count;
    logic             pop;
    t_result          head;

    assign pop  = o_result.valid && o_result.ready;
    assign head = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res_a;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr_ptr + 1'b1] <= i_push.res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + PtrW'(pop);
            r_count  <= r_count + (PtrW+1)'(i_push.count) - (PtrW+1)'(pop);
        end
    end

    assign o_count              = r_count;
    assign o_result.valid       = (r_count != '0);
    assign o_result.kind        = head.kind;
    assign o_result.row         = head.row;
    assign o_result.col         = head.col;
    assign o_result.value       = head.value;
    assign o_result.cell_end    = head.cell_end;
    assign o_result.last_result = head.last_result;

    `XLT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (PtrW+1)'(FIFO_DEPTH), "fifo count past depth")
    `XLT_ASSERT(a_no_overflow, i_clk, i_rst_n, (i_push.count != 2'd0) |-> (r_count <= (PtrW+1)'(FIFO_DEPTH) - (PtrW+1)'(i_push.count)), "fifo push overflows")

endmodule
